// ===== rtl/rfa_pkg.sv =====
package rfa_pkg;

  localparam int W    = 32;
  localparam int EW   = 6;
  localparam int GK_W = $clog2(W);

  localparam logic [2:0] MODE_ADD = 3'd0;
  localparam logic [2:0] MODE_SUB = 3'd1;
  localparam logic [2:0] MODE_MUL = 3'd2;
  localparam logic [2:0] MODE_DIV = 3'd3;
  localparam logic [2:0] MODE_POW = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZERO = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  localparam logic [W-1:0] WHALF = {1'b1, {(W-1){1'b0}}};

  function automatic logic is_neg(input logic [W-1:0] v);
    return v[W-1];
  endfunction

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    return v[W-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== rtl/rational_fraction_alu.sv =====
// Result path: an unused mode, a zero operand denominator in add/subtract or a zero power
// exponent goes straight to the output state. Otherwise the result waits on the serial
// divider (two divides per reduction, three more for add/subtract with unequal
// denominators) and binary gcd (one step per cycle). Power runs two multiplies and a
// reduction per exponent step.
// Throughput: one item at a time, busy drops as the strobe rises. Reset: sync, to idle.
module rational_fraction_alu (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             mode,
  input  logic [rfa_pkg::W-1:0]  a_num,
  input  logic [rfa_pkg::W-1:0]  a_den,
  input  logic [rfa_pkg::W-1:0]  b_num,
  input  logic [rfa_pkg::W-1:0]  b_den,
  input  logic [rfa_pkg::EW-1:0] exponent,
  output logic                   done,
  output logic [rfa_pkg::W-1:0]  res_num,
  output logic [rfa_pkg::W-1:0]  res_den,
  output logic [1:0]             status
);
  import rfa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_GCD, S_DIV,
    S_AS_Q, S_AS_LCM, S_AS_LCMW, S_AS_DA, S_AS_MA, S_AS_MAW,
    S_AS_DB, S_AS_MB, S_AS_MBW, S_AS_SUM,
    S_M2, S_M2W, S_M2X,
    S_PW, S_PW1, S_PW2, S_PW3,
    S_RED, S_RD_N, S_RD_D, S_RD_F, S_OUT
  } state_t;

  state_t state, dret;

  logic [2:0]      md;
  logic [W-1:0]    an, ad, bn, bd, rn, rd, tq;
  logic [W-1:0]    ga, gb, g;
  logic [GK_W-1:0] gk;
  logic [EW-1:0]   cnt;
  logic            zero, ovf, red;

  logic signed [W:0]     mx, my;
  logic signed [2*W+1:0] p;
  logic                  p_ovf;

  logic         dv_start, dv_done;
  logic [W-1:0] dv_a, dv_b, dv_q;

  logic [W-1:0] sum, q_s, rd_n;
  logic         s_sign, sum_ovf;

  rfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_a),
    .divisor  (dv_b),
    .done     (dv_done),
    .quo      (dv_q)
  );

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    p <= mx * my;
  end

  assign p_ovf = (p[2*W+1:W-1] != '0) && (p[2*W+1:W-1] != '1);

  always_comb begin
    mx = '0;
    my = '0;
    unique case (state)
      S_AS_LCM: begin mx = {1'b0, dv_q}; my = {1'b0, mag(bd)}; end
      S_AS_MA:  begin mx = {an[W-1], an}; my = {tq[W-1], tq}; end
      S_AS_MB:  begin mx = {bn[W-1], bn}; my = {tq[W-1], tq}; end
      S_M2: begin
        mx = {an[W-1], an};
        my = (md == MODE_DIV) ? {bd[W-1], bd} : {bn[W-1], bn};
      end
      S_M2W: begin
        mx = {ad[W-1], ad};
        my = (md == MODE_DIV) ? {bn[W-1], bn} : {bd[W-1], bd};
      end
      S_PW:  begin mx = {an[W-1], an}; my = {rn[W-1], rn}; end
      S_PW1: begin mx = {ad[W-1], ad}; my = {rd[W-1], rd}; end
      default: ;
    endcase
  end

  always_comb begin
    dv_start = 1'b1;
    dv_a     = '0;
    dv_b     = '0;
    unique case (state)
      S_AS_Q:    begin dv_a = mag(ad);         dv_b = g;       end
      S_AS_LCMW: begin dv_a = mag(p[W-1:0]);   dv_b = mag(ad); end
      S_AS_MAW:  begin dv_a = mag(rd);         dv_b = mag(bd); end
      S_RD_N:    begin dv_a = mag(rn);         dv_b = g;       end
      S_RD_D:    begin dv_a = mag(rd);         dv_b = g;       end
      default:   dv_start = 1'b0;
    endcase
  end

  // truncating signed quotient sign for the lcm scale factors
  assign s_sign = is_neg(rd) ^ is_neg((state == S_AS_DA) ? ad : bd);
  assign q_s    = s_sign ? (~dv_q + 1'b1) : dv_q;

  assign sum = (md == MODE_ADD) ? (an + bn) : (an - bn);
  assign sum_ovf = (md == MODE_ADD)
                 ? (is_neg(an) == is_neg(bn)) && (is_neg(sum) != is_neg(an))
                 : (is_neg(an) != is_neg(bn)) && (is_neg(sum) != is_neg(an));

  assign rd_n = is_neg(rd) ? (~dv_q + 1'b1) : dv_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      dret  <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (state == S_OUT);
      unique case (state)
        S_IDLE: if (start) begin
          md   <= mode;
          an   <= a_num;
          ad   <= a_den;
          bn   <= b_num;
          bd   <= b_den;
          cnt  <= exponent;
          zero <= 1'b0;
          ovf  <= 1'b0;
          red  <= 1'b0;
          if (mode == MODE_ADD || mode == MODE_SUB) begin
            if (a_den == '0 || b_den == '0) begin
              zero  <= 1'b1;
              state <= S_OUT;
            end else begin
              rd <= a_den;
              if (a_den == b_den) begin
                state <= S_AS_SUM;
              end else begin
                ga    <= mag(a_den);
                gb    <= mag(b_den);
                gk    <= '0;
                state <= S_GCD;
              end
            end
          end else if (mode == MODE_MUL || mode == MODE_DIV) begin
            state <= S_M2;
          end else if (mode == MODE_POW) begin
            rn    <= W'(1);
            rd    <= W'(1);
            state <= (exponent == '0) ? S_OUT : S_PW;
          end else begin
            zero  <= 1'b1;
            state <= S_OUT;
          end
        end
        S_GCD: begin
          if (ga == '0) begin
            g     <= gb << gk;
            state <= red ? S_RD_N : S_AS_Q;
          end else if (!ga[0] && !gb[0]) begin
            ga <= ga >> 1;
            gb <= gb >> 1;
            gk <= gk + 1'b1;
          end else if (!ga[0]) begin
            ga <= ga >> 1;
          end else if (!gb[0]) begin
            gb <= gb >> 1;
          end else if (ga >= gb) begin
            ga <= ga - gb;
          end else begin
            gb <= gb - ga;
          end
        end
        S_DIV: if (dv_done) state <= dret;
        S_AS_Q: begin
          dret  <= S_AS_LCM;
          state <= S_DIV;
        end
        S_AS_LCM: state <= S_AS_LCMW;
        S_AS_LCMW: begin
          if (p_ovf) ovf <= 1'b1;
          rd    <= p[W-1:0];
          dret  <= S_AS_DA;
          state <= S_DIV;
        end
        S_AS_DA, S_AS_DB: begin
          if (!s_sign && dv_q[W-1]) ovf <= 1'b1;
          tq    <= q_s;
          state <= (state == S_AS_DA) ? S_AS_MA : S_AS_MB;
        end
        S_AS_MA: state <= S_AS_MAW;
        S_AS_MAW: begin
          if (p_ovf) ovf <= 1'b1;
          an    <= p[W-1:0];
          dret  <= S_AS_DB;
          state <= S_DIV;
        end
        S_AS_MB: state <= S_AS_MBW;
        S_AS_MBW: begin
          if (p_ovf) ovf <= 1'b1;
          bn    <= p[W-1:0];
          state <= S_AS_SUM;
        end
        S_AS_SUM: begin
          if (sum_ovf) ovf <= 1'b1;
          rn    <= sum;
          state <= S_RED;
        end
        S_M2: state <= S_M2W;
        S_M2W: begin
          if (p_ovf) ovf <= 1'b1;
          rn    <= p[W-1:0];
          state <= S_M2X;
        end
        S_M2X: begin
          if (p_ovf) ovf <= 1'b1;
          rd    <= p[W-1:0];
          state <= S_RED;
        end
        S_PW: state <= S_PW1;
        S_PW1: begin
          if (p_ovf) ovf <= 1'b1;
          rn    <= p[W-1:0];
          state <= S_PW2;
        end
        S_PW2: begin
          if (p_ovf) ovf <= 1'b1;
          rd    <= p[W-1:0];
          state <= S_RED;
        end
        S_PW3: begin
          cnt   <= cnt - 1'b1;
          state <= (cnt == EW'(1)) ? S_OUT : S_PW;
        end
        S_RED: begin
          if (rd == '0) begin
            zero  <= 1'b1;
            state <= S_OUT;
          end else begin
            ga    <= mag(rn);
            gb    <= mag(rd);
            gk    <= '0;
            red   <= 1'b1;
            state <= S_GCD;
          end
        end
        S_RD_N: begin
          dret  <= S_RD_D;
          state <= S_DIV;
        end
        S_RD_D: begin
          rn    <= is_neg(rn) ? (~dv_q + 1'b1) : dv_q;
          dret  <= S_RD_F;
          state <= S_DIV;
        end
        S_RD_F: begin
          if (is_neg(rd_n)) begin
            if (rn == WHALF || rd_n == WHALF) ovf <= 1'b1;
            rn <= ~rn + 1'b1;
            rd <= ~rd_n + 1'b1;
          end else begin
            rd <= rd_n;
          end
          state <= (md == MODE_POW) ? S_PW3 : S_OUT;
        end
        S_OUT: begin
          res_num <= zero ? '0 : rn;
          res_den <= zero ? '0 : rd;
          status  <= zero ? ST_ZERO : (ovf ? ST_OVF : ST_OK);
          state   <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("item accepted but not busy");
  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_ZERO |-> res_num == '0 && res_den == '0)
    else $error("zero status with nonzero result");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status == ST_OK || status == ST_ZERO || status == ST_OVF)
    else $error("bad status code");
`endif

endmodule

// ===== rtl/rfa_div.sv =====
module rfa_div (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [rfa_pkg::W-1:0] dividend,
  input  logic [rfa_pkg::W-1:0] divisor,
  output logic                  done,
  output logic [rfa_pkg::W-1:0] quo
);
  import rfa_pkg::*;

  logic [W-1:0]    dsr;
  logic [W:0]      rem;
  logic [GK_W:0]   cnt;
  logic            run;
  logic [W:0]      trial;
  logic [W:0]      diff;

  assign trial = {rem[W-1:0], quo[W-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      run  <= 1'b1;
      cnt  <= (GK_W+1)'(W);
      quo  <= dividend;
      dsr  <= divisor;
      rem  <= '0;
      done <= 1'b0;
    end else if (run) begin
      if (!diff[W]) begin
        rem <= diff;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[W-2:0], 1'b0};
      end
      cnt  <= cnt - 1'b1;
      done <= (cnt == (GK_W+1)'(1));
      if (cnt == (GK_W+1)'(1)) begin
        run <= 1'b0;
      end
    end else begin
      done <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(run) && !run) else $error("done without a finished run");
  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    !run |-> cnt == '0) else $error("count left over");
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    start |=> run) else $error("start did not run");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
  import rfa_pkg::*;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic          busy;
  logic [2:0]    mode = '0;
  logic [W-1:0]  a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic [EW-1:0] exponent = '0;
  logic          done;
  logic [W-1:0]  res_num, res_den;
  logic [1:0]    status;

  typedef struct {
    logic [W-1:0] num;
    logic [W-1:0] den;
    logic [1:0]   st;
  } frac_t;

  frac_t expected_q[$];
  int    errors = 0;
  int    n_items = 0;
  int    n_results = 0;
  bit    no_idle = 1'b0;

  rational_fraction_alu i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  function automatic logic [W-1:0] neg_w(input logic [W-1:0] v);
    return ~v + 1'b1;
  endfunction

  function automatic logic [63:0] mag64(input logic [W-1:0] v);
    logic [63:0] r;
    r = 64'(v[W-1] ? neg_w(v) : v);
    return r;
  endfunction

  function automatic logic [63:0] gcd64(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic logic [W-1:0] mul_w(input logic [W-1:0] x, input logic [W-1:0] y,
                                         inout bit ovf);
    logic [63:0] mx, my, lim;
    mx = mag64(x);
    my = mag64(y);
    lim = (x[W-1] != y[W-1]) ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (mx != 0 && my > lim / mx) ovf = 1'b1;
    return x * y;
  endfunction

  function automatic logic [W-1:0] div_w(input logic [W-1:0] x, input logic [W-1:0] y,
                                         inout bit ovf);
    logic [63:0] q;
    bit s;
    q = mag64(x) / mag64(y);
    s = x[W-1] != y[W-1];
    if (!s && q > 64'h7FFF_FFFF) ovf = 1'b1;
    return s ? neg_w(q[W-1:0]) : q[W-1:0];
  endfunction

  function automatic void reduce_frac(inout logic [W-1:0] n, inout logic [W-1:0] d,
                                      inout bit zero, inout bit ovf);
    logic [63:0] mn, md, g;
    if (d == 0) begin
      zero = 1'b1;
      return;
    end
    mn = mag64(n);
    md = mag64(d);
    g = gcd64(mn, md);
    mn = mn / g;
    md = md / g;
    n = n[W-1] ? neg_w(mn[W-1:0]) : mn[W-1:0];
    d = d[W-1] ? neg_w(md[W-1:0]) : md[W-1:0];
    if (d[W-1]) begin
      if (n == WHALF || d == WHALF) ovf = 1'b1;
      n = neg_w(n);
      d = neg_w(d);
    end
  endfunction

  function automatic frac_t predict_fraction(input logic [2:0] m, input logic [W-1:0] an_i,
      input logic [W-1:0] ad, input logic [W-1:0] bn_i, input logic [W-1:0] bd,
      input logic [EW-1:0] ex);
    logic [W-1:0] an, bn, rn, rd;
    logic [63:0] ma, mb, qa;
    bit zero, ovf;
    frac_t r;
    an = an_i;
    bn = bn_i;
    rn = '0;
    rd = '0;
    zero = 1'b0;
    ovf = 1'b0;
    if (m == MODE_ADD || m == MODE_SUB) begin
      if (ad == 0 || bd == 0) begin
        zero = 1'b1;
      end else begin
        rd = ad;
        if (ad != bd) begin
          ma = mag64(ad);
          mb = mag64(bd);
          qa = ma / gcd64(ma, mb);
          if (mb > 64'h7FFF_FFFF / qa) ovf = 1'b1;
          rd = W'(qa * mb);
          an = mul_w(an, div_w(rd, ad, ovf), ovf);
          bn = mul_w(bn, div_w(rd, bd, ovf), ovf);
        end
        rn = (m == MODE_ADD) ? an + bn : an - bn;
        if (m == MODE_ADD && an[W-1] == bn[W-1] && rn[W-1] != an[W-1]) ovf = 1'b1;
        if (m == MODE_SUB && an[W-1] != bn[W-1] && rn[W-1] != an[W-1]) ovf = 1'b1;
        reduce_frac(rn, rd, zero, ovf);
      end
    end else if (m == MODE_MUL) begin
      rn = mul_w(an, bn, ovf);
      rd = mul_w(ad, bd, ovf);
      reduce_frac(rn, rd, zero, ovf);
    end else if (m == MODE_DIV) begin
      rn = mul_w(an, bd, ovf);
      rd = mul_w(ad, bn, ovf);
      reduce_frac(rn, rd, zero, ovf);
    end else if (m == MODE_POW) begin
      rn = 1;
      rd = 1;
      for (int i = 0; i < ex && !zero; i++) begin
        rn = mul_w(an, rn, ovf);
        rd = mul_w(ad, rd, ovf);
        reduce_frac(rn, rd, zero, ovf);
      end
    end else begin
      zero = 1'b1;
    end
    if (zero) begin
      r.num = '0;
      r.den = '0;
      r.st = ST_ZERO;
    end else begin
      r.num = rn;
      r.den = rd;
      r.st = ovf ? ST_OVF : ST_OK;
    end
    return r;
  endfunction

  task automatic send_item(input logic [2:0] m, input logic [W-1:0] an, input logic [W-1:0] ad,
                           input logic [W-1:0] bn, input logic [W-1:0] bd,
                           input logic [EW-1:0] ex);
    @(negedge clk);
    while (busy || (!no_idle && $urandom_range(0, 99) < 29)) @(negedge clk);
    mode = m;
    a_num = an;
    a_den = ad;
    b_num = bn;
    b_den = bd;
    exponent = ex;
    start = 1'b1;
    expected_q = {expected_q, predict_fraction(m, an, ad, bn, bd, ex)};
    n_items++;
    @(negedge clk);
    start = 1'b0;
  endtask

  always @(posedge clk) begin
    frac_t e;
    if (!rst && done) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h/%h status %0d", $time, res_num, res_den, status);
      end else begin
        e = expected_q.pop_front();
        if (res_num !== e.num) begin
          errors++;
          $display("%0t: res_num expected %h actual %h", $time, e.num, res_num);
        end
        if (res_den !== e.den) begin
          errors++;
          $display("%0t: res_den expected %h actual %h", $time, e.den, res_den);
        end
        if (status !== e.st) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, e.st, status);
        end
      end
    end
  end

  function automatic logic [W-1:0] rand_word(input bit nonzero);
    logic [W-1:0] v;
    int k;
    k = $urandom_range(0, 99);
    if (k < 40) v = W'($urandom_range(0, 40)) - W'(20);
    else if (k < 55) v = W'($urandom_range(0, 4000)) - W'(2000);
    else if (k < 62) v = (k & 1) ? WHALF : ~WHALF;
    else v = $urandom;
    if (nonzero && v == 0) v = 1;
    return v;
  endfunction

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    send_item(MODE_ADD, 1, 2, 1, 3, 0);
    send_item(MODE_SUB, 1, 2, 1, 2, 0);
    send_item(MODE_ADD, 5, 0, 1, 3, 0);
    send_item(MODE_SUB, 5, 7, 1, 0, 0);
    send_item(MODE_ADD, ~WHALF, 1, 1, 1, 0);
    send_item(MODE_SUB, WHALF, 1, 1, 1, 0);
    send_item(MODE_ADD, 1, 65536, 1, 65537, 0);
    send_item(MODE_MUL, 6, -4, -3, 9, 0);
    send_item(MODE_MUL, WHALF, 1, -1, 1, 0);
    send_item(MODE_MUL, 65536, 1, 65536, 1, 0);
    send_item(MODE_MUL, 1, 0, 3, 4, 0);
    send_item(MODE_DIV, 3, 4, 0, 5, 0);
    send_item(MODE_DIV, -7, 9, 14, -3, 0);
    send_item(MODE_DIV, WHALF, 1, 1, 1, 0);
    send_item(MODE_DIV, 1, WHALF, 1, 1, 0);
    send_item(MODE_POW, 5, 7, 0, 0, 0);
    send_item(MODE_POW, 0, 0, 0, 0, 0);
    send_item(MODE_POW, -2, 3, 0, 0, 5);
    send_item(MODE_POW, 2, 1, 0, 0, 63);
    send_item(MODE_POW, 3, 0, 0, 0, 2);
    send_item(3'd5, 1, 1, 1, 1, 1);
    send_item(3'd6, -1, -1, -1, -1, 3);
    send_item(3'd7, WHALF, WHALF, ~WHALF, ~WHALF, '1);
    send_item(MODE_ADD, '1, '1, WHALF, WHALF, '1);
  endtask

  task automatic test_random(input int count);
    logic [2:0] m;
    logic [EW-1:0] ex;
    bit bad;
    for (int i = 0; i < count; i++) begin
      no_idle = (i >= count / 3 && i < count / 2);
      m = ($urandom_range(0, 99) < 5) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      ex = ($urandom_range(0, 99) < 4) ? EW'($urandom) : EW'($urandom_range(0, 6));
      bad = $urandom_range(0, 99) < 4;
      send_item(m, rand_word(0), rand_word(!bad), rand_word(0), rand_word(!bad), ex);
    end
    no_idle = 1'b0;
  endtask

  task automatic test_pause_drained();
    send_item(MODE_MUL, rand_word(0), rand_word(1), rand_word(0), rand_word(1), 0);
    wait_drained();
    send_item(MODE_ADD, rand_word(0), rand_word(1), rand_word(0), rand_word(1), 0);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(600);
    test_pause_drained();
    test_random(600);
    wait_drained();
    repeat (20) @(negedge clk);
    $display("Ran %0d items (%0d results): all five modes, unused modes, zero denominators,",
             n_items, n_results);
    $display("overflow extremes and powers up to exponent 63, with random start gaps.");
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== rational_fraction_alu.f =====
rtl/rfa_pkg.sv
rtl/rfa_div.sv
rtl/rational_fraction_alu.sv
tb/sv/tb_top.sv
